// File: hw/rtl/sorted_array_priority_queue_macros.svh
// Assertion macros used by the checker of the priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SAPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sapq: implication failed");

// Next-cycle implication, off while reset is high.
`define SAPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sapq: next-cycle implication failed");

`endif

// File: hw/rtl/sapq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SERVE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [7:0]  priority_req;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] served_tag;
      logic [7:0]  served_priority;
      logic [6:0]  occupancy;
   } rsp_type;

   // One stored entry of the queue.
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] tag;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic        insert;
      logic        serve;
      entry_type   entry;
   } cmd_type;

endpackage

`default_nettype wire

// File: hw/rtl/sapq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sapq_cell
   import sapq_pkg::*;
(
   input  wire logic      clock,
   input  wire cmd_type   cmd,
   input  wire logic      occupied,
   input  wire logic      at_tail,
   input  wire entry_type left_entry,
   input  wire logic      left_lt,
   input  wire entry_type right_entry,
   output entry_type      entry,
   output logic           lt
);

   entry_type entry_ff;
   entry_type entry_in;

   // New entry sorts strictly before the one held here.
   assign lt = occupied && (cmd.entry.prio < entry_ff.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (left_lt) begin
            entry_in = left_entry;
         end else if (lt || at_tail) begin
            entry_in = cmd.entry;
         end
      end else if (cmd.serve) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_array_priority_queue.sv
// Sorted priority queue of QUEUE_DEPTH entries, each an 8-bit priority and a
// 16-bit tag, kept in a chain of compare-and-shift cells with the head (smallest
// priority value) in cell 0. An insert item places its entry behind every entry
// of lower or equal priority value, so equal priorities leave in arrival order; a
// serve item removes the head and returns it. Every item yields exactly one
// result item: status OK, FULL (insert into a full queue) or EMPTY (serve from
// an empty queue); a rejected item leaves the queue untouched. served_tag and
// served_priority are zero unless a serve succeeded, and occupancy gives the
// low seven bits of the entry count after the item. Rate: one item per clock
// cycle unless stalled; the result is registered and appears in the cycle after
// acceptance. Each cell does one 8-bit compare and a neighbour select, so the
// whole insert or serve completes in the cycle the item is accepted. The input
// stalls only while a finished result is held by a stalled output. No clearing
// pass is needed after reset: the count alone marks which cells hold entries.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue
   import sapq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             accept;
   logic             full;
   logic             empty;
   cmd_type          cmd;
   logic [CNT_W+6:0] count_ext;

   entry_type        cell_entry [QUEUE_DEPTH];
   logic             cell_lt    [QUEUE_DEPTH];

   // Hold the input while a result waits on a stalled output.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // Broadcast the command; a rejected item reaches no cell.
   always_comb begin
      cmd.insert      = accept && (req_item.mode == MODE_INSERT) && !full;
      cmd.serve       = accept && (req_item.mode == MODE_SERVE) && !empty;
      cmd.entry.prio  = req_item.priority_req;
      cmd.entry.tag   = req_item.tag;
   end

   // The chain: each cell looks at its left neighbour's compare to decide
   // whether to shift right on insert, and takes its right neighbour on serve.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_lt;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_lt    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      sapq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CNT_W'(i) < count_ff),
         .at_tail     (CNT_W'(i) == count_ff),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .lt          (cell_lt[i])
      );
   end

   // Advance the count on an accepted insert or serve.
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.serve) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_ext = {7'd0, count_in};

   // Build the result item from the head cell and the new count.
   always_comb begin
      rsp_in                 = '0;
      rsp_in.occupancy       = count_ext[6:0];
      if (req_item.mode == MODE_INSERT) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else begin
         if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.served_tag      = cell_entry[0].tag;
            rsp_in.served_priority = cell_entry[0].prio;
         end
      end
   end

   // Keep a result while the output stalls; drop it once taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sapq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_array_priority_queue_macros.svh"

module sapq_checker
   import sapq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
)
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   // A stalled result stays put.
   `SAPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // Every accepted item shows a result in the next cycle.
   `SAPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && !req_stall, rsp_valid)

   // Only a successful serve carries an entry out.
   `SAPQ_ASSERT_IMP(a_reject_clean, clock, reset, rsp_valid && (rsp_item.status != STATUS_OK), (rsp_item.served_tag == '0) && (rsp_item.served_priority == '0))

   // A full rejection reports a full queue, an empty rejection an empty one.
   `SAPQ_ASSERT_IMP(a_full_occ, clock, reset, rsp_valid && (rsp_item.status == STATUS_FULL), rsp_item.occupancy == 7'(QUEUE_DEPTH))
   `SAPQ_ASSERT_IMP(a_empty_occ, clock, reset, rsp_valid && (rsp_item.status == STATUS_EMPTY), rsp_item.occupancy == 7'd0)

endmodule

bind sorted_array_priority_queue sapq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sapq_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted-array priority queue. Every accepted
// request is run through a behavioural copy of the queue, and each result
// item leaving the block is compared against the oldest prediction.
module tb_top;
   import sapq_pkg::*;

   localparam int DEPTH      = 64;
   localparam int STALL_PCT  = 33;     // idle/stall rate on both sides, in percent
   localparam int HOLD_LEN   = 300;    // length of the one long receiver hold-off
   localparam int HOLD_AT    = 1400;   // results drained before the hold-off starts
   localparam int STALL_GIVE = 2000;   // cycles with no handshake before giving up
   localparam int PHASES     = 8;
   localparam int PHASE_LEN  = 230;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // Items waiting to go out, the mirrored queue contents and the results
   // still owed by the block.
   req_type   pending_items[$];
   entry_type ranked_entries[$];
   rsp_type   awaited_results[$];
   int        error_count = 0;

   sorted_array_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Apply one request to the mirrored queue and return the result the block
   // must give for it. Inserts go behind every entry of lower or equal
   // priority value, so ties leave in arrival order; rejected items leave the
   // contents untouched.
   function automatic rsp_type predict_queue_result(req_type r);
      rsp_type   res;
      entry_type ent;
      int        pos;
      res = '0;
      if (r.mode == MODE_INSERT) begin
         if (ranked_entries.size() >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = ranked_entries.size();
            while (pos > 0 && r.priority_req < ranked_entries[pos - 1].prio)
               pos--;
            ent.prio = r.priority_req;
            ent.tag  = r.tag;
            ranked_entries.insert(pos, ent);
         end
      end else begin
         if (ranked_entries.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            ent = ranked_entries.pop_front();
            res.served_tag      = ent.tag;
            res.served_priority = ent.prio;
         end
      end
      res.occupancy = 7'(ranked_entries.size());
      return res;
   endfunction

   function automatic req_type make_request(logic mode, logic [7:0] prio, logic [15:0] tag);
      req_type r;
      r.mode         = mode;
      r.priority_req = prio;
      r.tag          = tag;
      return r;
   endfunction

   // Random request: insert_pct sets the mix of inserts against serves. Half
   // the priorities come from a narrow band so that ties are common.
   function automatic req_type random_request(int insert_pct);
      logic       mode;
      logic [7:0] prio;
      mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_SERVE;
      if ($urandom_range(1) == 1)
         prio = 8'($urandom_range(3));
      else
         prio = 8'($urandom_range(255));
      return make_request(mode, prio, 16'($urandom_range(65535)));
   endfunction

   // Driver: predict on acceptance, then load the next item unless idling.
   // A stalled item is held as it is; the idle choice is only made once the
   // channel is free, so valid never follows stall.
   always @(posedge clock) begin : drive_proc
      logic next_valid;
      int   sent_count;
      if (reset) begin
         req_valid  <= 1'b0;
         sent_count = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            awaited_results.push_back(predict_queue_result(req_item));
            sent_count++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() != 0) begin
            // keep a calm stretch with no idling at all
            if ((sent_count >= 1000 && sent_count < 1300)
                || $urandom_range(99) >= STALL_PCT) begin
               req_item   <= pending_items.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: random stalls, a calm window, and one long hold-off that lets
   // the block fill up and push back on its input.
   always @(posedge clock) begin : stall_proc
      int drained_count;
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_stall     <= 1'b0;
         drained_count = 0;
         hold_left     = 0;
         hold_done     = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            drained_count++;
         if (!hold_done && drained_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (drained_count >= 600 && drained_count < 900) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < STALL_PCT);
         end
      end
   end

   // Monitor: compare each accepted result item with the oldest prediction.
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result item: status %0d tag %h prio %0d occupancy %0d",
                   rsp_item.status, rsp_item.served_tag, rsp_item.served_priority,
                   rsp_item.occupancy);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.served_tag !== want.served_tag) begin
               $error("served_tag: expected %h, got %h", want.served_tag,
                      rsp_item.served_tag);
               error_count++;
            end
            if (rsp_item.served_priority !== want.served_priority) begin
               $error("served_priority: expected %0d, got %0d", want.served_priority,
                      rsp_item.served_priority);
               error_count++;
            end
            if (rsp_item.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy,
                      rsp_item.occupancy);
               error_count++;
            end
         end
      end
   end

   // Watchdog: give up when no handshake happens on either side for too long.
   always @(posedge clock) begin : watchdog_proc
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_GIVE) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Hold the sender back until every item has gone out and every result
   // has come back.
   task automatic wait_for_drain();
      while (pending_items.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus_proc
      int phase;
      int k;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: serve from empty, priority and tag extremes, ties leaving
      // in arrival order, a tie with the head, then drain past empty.
      pending_items.push_back(make_request(MODE_SERVE, 8'hff, 16'hffff));
      pending_items.push_back(make_request(MODE_INSERT, 8'd0, 16'h0000));
      pending_items.push_back(make_request(MODE_INSERT, 8'd255, 16'hffff));
      pending_items.push_back(make_request(MODE_INSERT, 8'd128, 16'h0001));
      pending_items.push_back(make_request(MODE_INSERT, 8'd128, 16'h0002));
      pending_items.push_back(make_request(MODE_INSERT, 8'd128, 16'h0003));
      pending_items.push_back(make_request(MODE_INSERT, 8'd0, 16'h5555));
      pending_items.push_back(make_request(MODE_INSERT, 8'd255, 16'haaaa));
      pending_items.push_back(make_request(MODE_INSERT, 8'd127, 16'h8000));
      for (k = 0; k < 10; k++)
         pending_items.push_back(make_request(MODE_SERVE, 8'(k * 29), 16'(k * 7919)));
      wait_for_drain();

      // Random: alternate fill-biased and drain-biased phases so the queue
      // swings between full and empty, with one full pause half-way.
      for (phase = 0; phase < PHASES; phase++) begin
         for (k = 0; k < PHASE_LEN; k++)
            pending_items.push_back(random_request((phase % 2 == 0) ? 75 : 25));
         if (phase == 3)
            wait_for_drain();
      end
      wait_for_drain();
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
